/* rtl/rre_pkg.sv */
// Shared types and constants for the rectangle raster engine.
// No dependencies; every other file imports this package.
package rre_pkg;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int FRAC_BITS_DEF  = 8;

  // Configuration register indexes and reset values
  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BACKGROUND    = 2'd2;

  localparam logic [9:0] CANVAS_WIDTH_RST  = 10'd1;
  localparam logic [9:0] CANVAS_HEIGHT_RST = 10'd1;
  localparam logic [7:0] BACKGROUND_RST    = 8'd48;

  localparam int PADDR_W = 4;

  // Operation codes
  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  // Controller -> datapath
  typedef struct packed {
    logic latch;     // capture item fields, rewind sweep counters
    logic prep;      // compute edge thresholds, issue cell read
    logic step;      // visit one cell
    logic load_out;  // load the result register
  } rre_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    op_t  op;
    logic draw_ok;     // width and height both positive
    logic area_ok;     // active canvas is not empty
    logic sweep_last;  // current cell is the last active one
  } rre_stat_t;

endpackage

/* rtl/rectangle_raster_engine.sv */
// Top level of the rectangle raster engine: character canvas with rectangle
// drawing. Depends on rre_pkg, rre_cfg, rre_ctrl and rre_datapath.
//
//   channel   direction  handshake            payload
//   in_*      input      in_valid/in_ready    operation, fill_mode, rect_*, draw_char, cell_*
//   out_*     output     out_valid/out_ready  status, cell_char
//   APB       input      psel/penable/pready  paddr, pwdata, prdata
//
// Draw and clear visit every active cell once through the single canvas write
// port. Read, rejected and unknown items skip the cell sweep.
// One item is in work at a time; the next is taken while a result waits.
// A stalled result holds the engine in its result state until taken.
// Reset clears control and configuration; canvas contents are undefined
// until a clear, and no clearing pass runs.
module rectangle_raster_engine #(
  parameter int MAX_WIDTH  = rre_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rre_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = rre_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_operation,
  input  logic                        in_fill_mode,
  input  logic signed [23:0]          in_rect_left,
  input  logic signed [23:0]          in_rect_top,
  input  logic signed [23:0]          in_rect_width,
  input  logic signed [23:0]          in_rect_height,
  input  logic [7:0]                  in_draw_char,
  input  logic [8:0]                  in_cell_row,
  input  logic [8:0]                  in_cell_col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_status,
  output logic [7:0]                  out_cell_char,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rre_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rre_pkg::*;

  localparam int COLS_W = $clog2(MAX_WIDTH + 1);
  localparam int ROWS_W = $clog2(MAX_HEIGHT + 1);

  logic [COLS_W-1:0] cols;
  logic [ROWS_W-1:0] rows;
  logic [7:0]        bg_char;
  rre_cmd_t          cmd;
  rre_stat_t         stat;

  rre_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cols_o   (cols),
    .rows_o   (rows),
    .bg_char_o(bg_char)
  );

  rre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rre_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .stat          (stat),
    .in_operation  (in_operation),
    .in_fill_mode  (in_fill_mode),
    .in_rect_left  (in_rect_left),
    .in_rect_top   (in_rect_top),
    .in_rect_width (in_rect_width),
    .in_rect_height(in_rect_height),
    .in_draw_char  (in_draw_char),
    .in_cell_row   (in_cell_row),
    .in_cell_col   (in_cell_col),
    .cols          (cols),
    .rows          (rows),
    .bg_char       (bg_char),
    .out_status    (out_status),
    .out_cell_char (out_cell_char)
  );

endmodule

/* rtl/rre_cfg.sv */
// Configuration register file on an APB-style port.
// Depends on rre_pkg; gives the saturated active canvas size to the datapath.
module rre_cfg #(
  parameter int MAX_WIDTH  = rre_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rre_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rre_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [$clog2(MAX_WIDTH+1)-1:0]    cols_o,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]   rows_o,
  output logic [7:0]                        bg_char_o
);
  import rre_pkg::*;

  localparam int COLS_W = $clog2(MAX_WIDTH + 1);
  localparam int ROWS_W = $clog2(MAX_HEIGHT + 1);
  localparam int CCW    = (COLS_W > 10) ? COLS_W : 10;
  localparam int RCW    = (ROWS_W > 10) ? ROWS_W : 10;

  logic [9:0] width_r, width_nxt;
  logic [9:0] height_r, height_nxt;
  logic [7:0] bg_r, bg_nxt;
  logic       wr_en;
  logic [1:0] idx;
  logic [CCW-1:0] w_ext, w_sat;
  logic [RCW-1:0] h_ext, h_sat;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    bg_nxt     = bg_r;
    if (wr_en) begin
      case (idx)
        REG_CANVAS_WIDTH:  width_nxt  = pwdata[9:0];
        REG_CANVAS_HEIGHT: height_nxt = pwdata[9:0];
        REG_BACKGROUND:    bg_nxt     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CANVAS_WIDTH_RST;
      height_r <= CANVAS_HEIGHT_RST;
      bg_r     <= BACKGROUND_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bg_r     <= bg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_CANVAS_WIDTH:  prdata = {22'd0, width_r};
      REG_CANVAS_HEIGHT: prdata = {22'd0, height_r};
      REG_BACKGROUND:    prdata = {24'd0, bg_r};
      default:           prdata = 32'd0;
    endcase
  end

  // Sizes above the memory bounds saturate
  assign w_ext = CCW'(width_r);
  assign h_ext = RCW'(height_r);
  assign w_sat = (w_ext > CCW'(MAX_WIDTH))  ? CCW'(MAX_WIDTH)  : w_ext;
  assign h_sat = (h_ext > RCW'(MAX_HEIGHT)) ? RCW'(MAX_HEIGHT) : h_ext;

  assign cols_o    = w_sat[COLS_W-1:0];
  assign rows_o    = h_sat[ROWS_W-1:0];
  assign bg_char_o = bg_r;

endmodule

/* rtl/rre_ctrl.sv */
// Controller state machine: sequences accept, setup, cell sweep and result.
// Depends on rre_pkg for the command and status structs.
module rre_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rre_pkg::rre_stat_t stat,
  output rre_pkg::rre_cmd_t  cmd
);
  import rre_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;
  logic   do_sweep;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign do_sweep = stat.area_ok &&
                    ((stat.op == OP_DRAW && stat.draw_ok) || stat.op == OP_CLEAR);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = do_sweep ? ST_SWEEP : ST_RESULT;
      ST_SWEEP:  if (stat.sweep_last) state_nxt = ST_RESULT;
      ST_RESULT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.latch    = accept;
    cmd.prep     = (state_r == ST_PREP);
    cmd.step     = (state_r == ST_SWEEP);
    cmd.load_out = (state_r == ST_RESULT) && out_free;
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/rre_datapath.sv */
// Datapath: item registers, edge thresholds, cell sweep counters, canvas
// memory and result register. Depends on rre_pkg; driven by rre_ctrl.
module rre_datapath #(
  parameter int MAX_WIDTH  = rre_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rre_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = rre_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  rre_pkg::rre_cmd_t                cmd,
  output rre_pkg::rre_stat_t               stat,
  input  logic [1:0]                       in_operation,
  input  logic                             in_fill_mode,
  input  logic signed [23:0]               in_rect_left,
  input  logic signed [23:0]               in_rect_top,
  input  logic signed [23:0]               in_rect_width,
  input  logic signed [23:0]               in_rect_height,
  input  logic [7:0]                       in_draw_char,
  input  logic [8:0]                       in_cell_row,
  input  logic [8:0]                       in_cell_col,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   cols,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]  rows,
  input  logic [7:0]                       bg_char,
  output logic                             out_status,
  output logic [7:0]                       out_cell_char
);
  import rre_pkg::*;

  localparam int COLS_W = $clog2(MAX_WIDTH + 1);
  localparam int ROWS_W = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int GW_A   = IDX_W + FRAC_BITS + 2;
  localparam int GW     = (GW_A > 26) ? GW_A : 26;
  localparam int RCW    = (ROWS_W > 9) ? ROWS_W : 9;
  localparam int CCW    = (COLS_W > 9) ? COLS_W : 9;

  localparam logic signed [GW-1:0] ONE    = GW'(1 << FRAC_BITS);
  localparam logic [ADDR_W-1:0]    STRIDE = ADDR_W'(MAX_WIDTH);

  // Item fields
  op_t                op_r;
  logic               fill_r;
  logic signed [23:0] x_r, y_r, w_r, h_r;
  logic [7:0]         char_r;
  logic [8:0]         cell_row_r, cell_col_r;

  // Edge thresholds
  logic signed [GW-1:0] xr_r, yb_r, x1_r, y1_r, xr1_r, yb1_r;

  // Sweep state
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_r;
  logic [ADDR_W-1:0]    addr_r, base_r;
  logic signed [GW-1:0] px_r, py_r;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;
  logic       status_r;
  logic [7:0] cell_char_r;

  logic              col_last, row_last;
  logic              in_x, in_y, edge_x, edge_y;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              read_ok;
  logic              status_calc;
  logic [7:0]        char_calc;
  logic signed [GW-1:0] x_g, y_g;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r       <= op_t'(in_operation);
      fill_r     <= in_fill_mode;
      x_r        <= in_rect_left;
      y_r        <= in_rect_top;
      w_r        <= in_rect_width;
      h_r        <= in_rect_height;
      char_r     <= in_draw_char;
      cell_row_r <= in_cell_row;
      cell_col_r <= in_cell_col;
    end
  end

  assign x_g = GW'(x_r);
  assign y_g = GW'(y_r);

  // Border: less than one unit from an edge, i.e. p < x+1 or p > x+w-1
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      xr_r  <= x_g + GW'(w_r);
      yb_r  <= y_g + GW'(h_r);
      x1_r  <= x_g + ONE;
      y1_r  <= y_g + ONE;
      xr1_r <= x_g + GW'(w_r) - ONE;
      yb1_r <= y_g + GW'(h_r) - ONE;
    end
  end

  assign col_last = (COLS_W'(col_r) + COLS_W'(1)) == cols;
  assign row_last = (ROWS_W'(row_r) + ROWS_W'(1)) == rows;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      col_r  <= '0;
      row_r  <= '0;
      addr_r <= '0;
      base_r <= '0;
      px_r   <= '0;
      py_r   <= '0;
    end else if (cmd.step) begin
      if (col_last) begin
        col_r  <= '0;
        px_r   <= '0;
        row_r  <= row_r + ROW_W'(1);
        py_r   <= py_r + ONE;
        base_r <= base_r + STRIDE;
        addr_r <= base_r + STRIDE;
      end else begin
        col_r  <= col_r + COL_W'(1);
        px_r   <= px_r + ONE;
        addr_r <= addr_r + ADDR_W'(1);
      end
    end
  end

  assign in_x   = (px_r >= x_g) && (px_r <= xr_r);
  assign in_y   = (py_r >= y_g) && (py_r <= yb_r);
  assign edge_x = (px_r < x1_r) || (px_r > xr1_r);
  assign edge_y = (py_r < y1_r) || (py_r > yb1_r);

  always_comb begin
    if (op_r == OP_CLEAR) begin
      mem_we    = cmd.step;
      mem_wdata = bg_char;
    end else begin
      mem_we    = cmd.step && in_x && in_y && (fill_r || edge_x || edge_y);
      mem_wdata = char_r;
    end
  end

  assign rd_addr = ADDR_W'(cell_row_r) * STRIDE + ADDR_W'(cell_col_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  assign read_ok = (RCW'(cell_row_r) < RCW'(rows)) && (CCW'(cell_col_r) < CCW'(cols));

  always_comb begin
    char_calc = 8'd0;
    unique case (op_r)
      OP_DRAW:  status_calc = !stat.draw_ok;
      OP_READ: begin
        status_calc = !read_ok;
        if (read_ok) char_calc = rdata_r;
      end
      OP_CLEAR: status_calc = 1'b0;
      OP_BAD:   status_calc = 1'b1;
      default:  status_calc = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r    <= status_calc;
      cell_char_r <= char_calc;
    end
  end

  always_comb begin
    stat.op         = op_r;
    stat.draw_ok    = !w_r[23] && (w_r != '0) && !h_r[23] && (h_r != '0);
    stat.area_ok    = (cols != '0) && (rows != '0);
    stat.sweep_last = col_last && row_last;
  end

  assign out_status    = status_r;
  assign out_cell_char = cell_char_r;

endmodule

/* rtl/rre_checker.sv */
// Port-level checks for the rectangle raster engine, bound to the top level.
// Depends on rre_pkg and rectangle_raster_engine.
module rre_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_status,
  input logic [7:0] out_cell_char,
  input logic       pready
);
  import rre_pkg::*;

  // Leaving reset the engine is idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("engine not idle after reset");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in work");

  // Rejected items carry no character
  a_reject_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_cell_char == 8'd0))
    else $error("rejected item with nonzero character");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_cell_char)))
    else $error("stalled result changed");

  // Register port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

endmodule

bind rectangle_raster_engine rre_checker u_rre_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_cell_char(out_cell_char),
  .pready       (pready)
);

/* sim/tb_rectangle_raster_engine.sv */
// Self-checking bench for rectangle_raster_engine: clears, outline and filled
// rectangle draws and cell reads over several canvas sizes, checked against a
// local canvas image. Depends on rre_pkg and the rtl/ sources.
module tb_rectangle_raster_engine;
  import rre_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int MAX_H = MAX_HEIGHT_DEF;
  localparam int CANVAS_CELLS = MAX_W * MAX_H;
  localparam int ONE_I = 1 << FRAC_BITS_DEF;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned WATCHDOG_LIMIT = 1000000;

  typedef struct {
    op_t               op;
    logic              fill;
    logic signed [23:0] left;
    logic signed [23:0] top;
    logic signed [23:0] wid;
    logic signed [23:0] hgt;
    logic [7:0]        ch;
    logic [8:0]        row;
    logic [8:0]        col;
  } raster_cmd_t;

  typedef struct {
    logic       status;
    logic [7:0] cell_char;
  } cell_reply_t;

  typedef enum logic [1:0] {RX_STEADY, RX_HALF, RX_SPARSE, RX_BUSY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = '0;
  logic        in_fill_mode = 1'b0;
  logic signed [23:0] in_rect_left = '0;
  logic signed [23:0] in_rect_top = '0;
  logic signed [23:0] in_rect_width = '0;
  logic signed [23:0] in_rect_height = '0;
  logic [7:0]  in_draw_char = '0;
  logic [8:0]  in_cell_row = '0;
  logic [8:0]  in_cell_col = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [7:0]  out_cell_char;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the engine's state
  bit [7:0]   canvas_img [CANVAS_CELLS];
  logic [9:0] cols_reg = CANVAS_WIDTH_RST;
  logic [9:0] rows_reg = CANVAS_HEIGHT_RST;
  logic [7:0] bg_reg = BACKGROUND_RST;

  raster_cmd_t pending_cmds [$];
  cell_reply_t expected_replies [$];
  int unsigned mismatches = 0;

  raster_cmd_t offered;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;

  rx_mode_t    rx_mode = RX_STEADY;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_served = 0;
  int unsigned hold_requests = 0;
  int unsigned quiet_cycles = 0;

  rectangle_raster_engine DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned active_span(logic [9:0] value, int unsigned limit);
    return (value > limit) ? limit : value;
  endfunction

  // Paint the local canvas for one command and return the reply it must give.
  function automatic cell_reply_t raster_apply(raster_cmd_t c);
    cell_reply_t rep;
    int unsigned ncols, nrows, i, j;
    longint x, y, xr, yb, px, py;
    logic border;
    rep.status = 1'b0;
    rep.cell_char = '0;
    ncols = active_span(cols_reg, MAX_W);
    nrows = active_span(rows_reg, MAX_H);
    case (c.op)
      OP_DRAW: begin
        if (c.wid <= 0 || c.hgt <= 0) begin
          rep.status = 1'b1;
        end else begin
          x = c.left;
          y = c.top;
          xr = x + c.wid;
          yb = y + c.hgt;
          for (i = 0; i < nrows; i++) begin
            py = longint'(i) * ONE_I;
            if (py < y || py > yb) continue;
            for (j = 0; j < ncols; j++) begin
              px = longint'(j) * ONE_I;
              if (px < x || px > xr) continue;
              border = (px - x < ONE_I) || (xr - px < ONE_I) ||
                       (py - y < ONE_I) || (yb - py < ONE_I);
              if (c.fill || border) canvas_img[i * MAX_W + j] = c.ch;
            end
          end
        end
      end
      OP_READ: begin
        if (c.row >= nrows || c.col >= ncols) rep.status = 1'b1;
        else rep.cell_char = canvas_img[c.row * MAX_W + c.col];
      end
      OP_CLEAR: begin
        for (i = 0; i < nrows; i++)
          for (j = 0; j < ncols; j++) canvas_img[i * MAX_W + j] = bg_reg;
      end
      default: rep.status = 1'b1;
    endcase
    return rep;
  endfunction

  // every field random; callers overwrite the ones that matter
  function automatic raster_cmd_t blank_cmd(op_t op);
    raster_cmd_t c;
    c.op = op;
    c.fill = 1'($urandom);
    c.left = 24'($urandom);
    c.top = 24'($urandom);
    c.wid = 24'($urandom);
    c.hgt = 24'($urandom);
    c.ch = 8'($urandom);
    c.row = 9'($urandom);
    c.col = 9'($urandom);
    return c;
  endfunction

  function automatic raster_cmd_t mk_draw(logic fill, int x, int y, int w, int h,
                                          logic [7:0] ch);
    raster_cmd_t c;
    c = blank_cmd(OP_DRAW);
    c.fill = fill;
    c.left = x[23:0];
    c.top = y[23:0];
    c.wid = w[23:0];
    c.hgt = h[23:0];
    c.ch = ch;
    return c;
  endfunction

  function automatic raster_cmd_t mk_read(int unsigned r, int unsigned col);
    raster_cmd_t c;
    c = blank_cmd(OP_READ);
    c.row = r[8:0];
    c.col = col[8:0];
    return c;
  endfunction

  function automatic logic [8:0] near_coord(int unsigned n);
    case ($urandom_range(0, 5))
      0: return 9'($urandom);
      1: return 9'(n);  // one past the last active index
      default: return (n == 0) ? 9'($urandom) : 9'($urandom_range(0, n - 1));
    endcase
  endfunction

  function automatic raster_cmd_t rand_cmd(int unsigned ncols, int unsigned nrows);
    raster_cmd_t c;
    int unsigned pick, span_x, span_y;
    pick = $urandom_range(0, 99);
    span_x = (ncols + 4) * ONE_I;
    span_y = (nrows + 4) * ONE_I;
    if (pick < 45) begin
      // rectangle placed around the active area, edges a few cells past it
      c = blank_cmd(OP_DRAW);
      c.left = 24'($urandom_range(0, span_x) - 3 * ONE_I);
      c.top = 24'($urandom_range(0, span_y) - 3 * ONE_I);
      c.wid = 24'($urandom_range(1, span_x));
      c.hgt = 24'($urandom_range(1, span_y));
      if ($urandom_range(0, 1)) begin
        // whole-cell coordinates land exactly on the inside/border limits
        c.left[7:0] = '0;
        c.top[7:0] = '0;
        c.wid[7:0] = '0;
        c.hgt[7:0] = '0;
      end
    end else if (pick < 55) begin
      c = blank_cmd(OP_DRAW);
    end else if (pick < 85) begin
      c = blank_cmd(OP_READ);
      c.row = near_coord(nrows);
      c.col = near_coord(ncols);
    end else if (pick < 93) begin
      c = blank_cmd(OP_CLEAR);
    end else begin
      c = blank_cmd(OP_BAD);
    end
    return c;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CANVAS_WIDTH:  cols_reg = value[9:0];
      REG_CANVAS_HEIGHT: rows_reg = value[9:0];
      REG_BACKGROUND:    bg_reg = value[7:0];
      default: ;
    endcase
  endtask

  task automatic setup_canvas(int unsigned w, int unsigned h, logic [7:0] bg);
    cfg_write(REG_CANVAS_WIDTH, {22'($urandom), w[9:0]});
    cfg_write(REG_CANVAS_HEIGHT, {22'($urandom), h[9:0]});
    cfg_write(REG_BACKGROUND, {24'($urandom), bg});
  endtask

  // sampled at the falling edge so driver and monitor updates have settled
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, logic [7:0] bg,
                           int unsigned n, bit squeeze, bit stray_write);
    int unsigned nc, nr, k;
    setup_canvas(w, h, bg);
    if (stray_write) cfg_write(REG_UNUSED, $urandom);
    nc = active_span(cols_reg, MAX_W);
    nr = active_span(rows_reg, MAX_H);
    // start from a cleared canvas so no read lands on an unwritten cell
    pending_cmds.push_back(blank_cmd(OP_CLEAR));
    if (squeeze) hold_requests++;
    for (k = 0; k < n; k++) pending_cmds.push_back(rand_cmd(nc, nr));
    drain();
  endtask

  // sender: bursts of items with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_replies.push_back(raster_apply(offered));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          offered = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_operation <= offered.op;
          in_fill_mode <= offered.fill;
          in_rect_left <= offered.left;
          in_rect_top <= offered.top;
          in_rect_width <= offered.wid;
          in_rect_height <= offered.hgt;
          in_draw_char <= offered.ch;
          in_cell_row <= offered.row;
          in_cell_col <= offered.col;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall pattern, plus long holds on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_HALF:   out_ready <= 1'($urandom);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_replies
    cell_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: result with none expected: status %0b cell_char %02h",
                 $time, out_status, out_cell_char);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0b actual %0b", $time, want.status, out_status);
          mismatches++;
        end
        if (out_cell_char !== want.cell_char) begin
          $display("%0t: cell_char expected %02h actual %02h",
                   $time, want.cell_char, out_cell_char);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned phase_w [7] = '{7, 1023, 2, 0, 13, 31, 20};
    int unsigned phase_h [7] = '{5, 3, 1023, 6, 11, 1, 16};
    int unsigned phase_n [7] = '{12, 8, 8, 4, 10, 8, 8};
    int unsigned p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: one-cell canvas, background '0'
    pending_cmds.push_back(blank_cmd(OP_CLEAR));
    pending_cmds.push_back(mk_read(0, 0));
    pending_cmds.push_back(mk_read(0, 1));
    pending_cmds.push_back(mk_read(1, 0));
    drain();

    setup_canvas(12, 9, 8'h2E);
    pending_cmds.push_back(blank_cmd(OP_CLEAR));
    pending_cmds.push_back(mk_draw(1'b1, 640, 256, 1280, 1024, 8'h46));
    pending_cmds.push_back(mk_read(3, 5));
    pending_cmds.push_back(mk_draw(1'b0, 0, 0, 11 * ONE_I, 8 * ONE_I, 8'hFF));
    pending_cmds.push_back(mk_read(0, 0));
    pending_cmds.push_back(mk_read(8, 11));
    pending_cmds.push_back(mk_read(4, 5));
    // outline narrower than two cells: every inside cell is on the border
    pending_cmds.push_back(mk_draw(1'b0, 6 * ONE_I, 2 * ONE_I, 384, 384, 8'h00));
    // width of one fraction step covers a single column
    pending_cmds.push_back(mk_draw(1'b1, ONE_I, 0, 1, 3 * ONE_I, 8'h72));
    pending_cmds.push_back(mk_draw(1'b1, 24'h7FFFFF, -8388608, 24'h7FFFFF, 24'h7FFFFF,
                                   8'h52));
    pending_cmds.push_back(mk_draw(1'b0, -8388608, -8388608, 24'h7FFFFF, 24'h7FFFFF,
                                   8'h52));
    pending_cmds.push_back(mk_draw(1'b0, -2 * ONE_I, -128, 4 * ONE_I, 3 * ONE_I, 8'h41));
    // nonpositive sizes are rejected
    pending_cmds.push_back(mk_draw(1'b1, 0, 0, 0, 4 * ONE_I, 8'h58));
    pending_cmds.push_back(mk_draw(1'b1, 0, 0, 4 * ONE_I, -8388608, 8'h58));
    pending_cmds.push_back(mk_draw(1'b0, 0, 0, -1, 4 * ONE_I, 8'h58));
    pending_cmds.push_back(blank_cmd(OP_BAD));
    pending_cmds.push_back(mk_read(9, 0));
    pending_cmds.push_back(mk_read(0, 12));
    pending_cmds.push_back(mk_read(511, 511));
    pending_cmds.push_back(mk_read(2, 1));
    pending_cmds.push_back(mk_read(1, 9));
    pending_cmds.push_back(mk_read(5, 3));
    pending_cmds.push_back(mk_read(0, 1));
    drain();

    for (p = 0; p < 7; p++)
      run_phase(phase_w[p], phase_h[p], (p == 1) ? 8'h00 : 8'($urandom), phase_n[p],
                p == 0, p == 3);

    // full canvas: corners and the last row and column
    setup_canvas(512, 512, 8'hFF);
    pending_cmds.push_back(blank_cmd(OP_CLEAR));
    pending_cmds.push_back(mk_draw(1'b1, 128064, 505 * ONE_I, 20 * ONE_I, 20 * ONE_I,
                                   8'h52));
    pending_cmds.push_back(mk_read(511, 511));
    pending_cmds.push_back(mk_read(0, 0));
    pending_cmds.push_back(mk_read(505, 500));
    pending_cmds.push_back(mk_read(505, 501));
    pending_cmds.push_back(mk_read(504, 501));
    pending_cmds.push_back(mk_read(0, 511));
    drain();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rre_pkg.sv
rtl/rre_cfg.sv
rtl/rre_ctrl.sv
rtl/rre_datapath.sv
rtl/rectangle_raster_engine.sv
rtl/rre_checker.sv
sim/tb_rectangle_raster_engine.sv
